// File: hdl/frx_pkg.sv
// Shared constants, state codes and types of the framed packet receiver.
package frx_pkg;

   localparam int MAX_PAYLOAD = 8;
   localparam int SUM_W       = $clog2(MAX_PAYLOAD * 255 + 1);
   localparam int BYTE_W      = 8;

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_LENGTH = 2'd1;
   localparam logic [1:0] PH_DATA   = 2'd2;
   localparam logic [1:0] PH_CHECK  = 2'd3;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_HEADER_BYTE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REPLY_HEADER = 2'd1;

   localparam logic [1:0] SLOT_ECHO   = 2'd0;
   localparam logic [1:0] SLOT_HEADER = 2'd1;
   localparam logic [1:0] SLOT_LENGTH = 2'd2;
   localparam logic [1:0] SLOT_CHECK  = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] echo;
      logic              ack;
      logic [BYTE_W-1:0] length;
      logic [BYTE_W-1:0] check;
      logic [BYTE_W-1:0] led;
   } frx_result_type;

endpackage

// File: hdl/frx_parser.sv
// Frame parser: phase, count, sum and LED registers, updated once per received byte.
module frx_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [frx_pkg::BYTE_W-1:0]    rx_byte,
   input  logic [frx_pkg::BYTE_W-1:0]    header_byte,
   output frx_pkg::frx_result_type       result
);

   logic [1:0]                  phase_ff, phase_in;
   logic [frx_pkg::BYTE_W-1:0]  length_ff, length_in;
   logic [frx_pkg::BYTE_W-1:0]  count_ff, count_in;
   logic [frx_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [frx_pkg::BYTE_W-1:0]  first_ff, first_in;
   logic [frx_pkg::BYTE_W-1:0]  led_ff, led_in;
   logic [frx_pkg::BYTE_W-1:0]  count_next;
   logic [frx_pkg::BYTE_W-1:0]  check;
   logic [frx_pkg::SUM_W-1:0]   sum_neg;
   logic                        ack;

   assign count_next = count_ff + 8'd1;
   assign sum_neg    = ~sum_ff + {{(frx_pkg::SUM_W-1){1'b0}}, 1'b1};
   assign check      = (sum_ff > frx_pkg::SUM_W'(255)) ? sum_neg[frx_pkg::BYTE_W-1:0]
                                                       : sum_ff[frx_pkg::BYTE_W-1:0];

   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      first_in  = first_ff;
      led_in    = led_ff;
      ack       = 1'b0;
      unique case (phase_ff)
         frx_pkg::PH_IDLE: begin
            sum_in   = '0;
            first_in = '0;
            count_in = '0;
            if (rx_byte == header_byte) begin
               phase_in = frx_pkg::PH_LENGTH;
            end
         end
         frx_pkg::PH_LENGTH: begin
            length_in = rx_byte;
            phase_in  = frx_pkg::PH_DATA;
         end
         frx_pkg::PH_DATA: begin
            if (count_ff < frx_pkg::BYTE_W'(frx_pkg::MAX_PAYLOAD)) begin
               if (count_ff == '0) begin
                  first_in = rx_byte;
               end
               sum_in = sum_ff + frx_pkg::SUM_W'(rx_byte);
            end
            count_in = count_next;
            if (count_next >= length_ff) begin
               phase_in = frx_pkg::PH_CHECK;
            end
         end
         frx_pkg::PH_CHECK: begin
            if (check == rx_byte) begin
               led_in = first_ff;
               ack    = 1'b1;
            end
            phase_in = frx_pkg::PH_IDLE;
         end
         default: begin
            phase_in = frx_pkg::PH_IDLE;
         end
      endcase
   end

   always_comb begin
      result.echo   = rx_byte;
      result.ack    = ack;
      result.length = length_ff;
      result.check  = check;
      result.led    = led_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= frx_pkg::PH_IDLE;
         length_ff <= '0;
         count_ff  <= '0;
         sum_ff    <= '0;
         first_ff  <= '0;
         led_ff    <= '0;
      end else if (load) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         first_ff  <= first_in;
         led_ff    <= led_in;
      end
   end

endmodule

// File: hdl/frx_reply.sv
// Result register that sends the echo and, after a good frame, the three reply bytes.
module frx_reply (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  frx_pkg::frx_result_type       result,
   input  logic [frx_pkg::BYTE_W-1:0]    reply_header,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [frx_pkg::BYTE_W-1:0]    rsp_tx_byte,
   output logic                          rsp_last,
   output logic [frx_pkg::BYTE_W-1:0]    rsp_led_value,
   output logic                          free
);

   logic                     valid_ff, valid_in;
   logic [1:0]               slot_ff, slot_in;
   frx_pkg::frx_result_type  rec_ff;
   logic                     take;

   assign take     = valid_ff && rsp_ready;
   assign rsp_last = !rec_ff.ack || (slot_ff == frx_pkg::SLOT_CHECK);
   assign free     = !valid_ff || (rsp_ready && rsp_last);

   always_comb begin
      unique case (slot_ff)
         frx_pkg::SLOT_ECHO:   rsp_tx_byte = rec_ff.echo;
         frx_pkg::SLOT_HEADER: rsp_tx_byte = reply_header;
         frx_pkg::SLOT_LENGTH: rsp_tx_byte = rec_ff.length;
         frx_pkg::SLOT_CHECK:  rsp_tx_byte = rec_ff.check;
         default:              rsp_tx_byte = rec_ff.echo;
      endcase
   end

   assign rsp_valid     = valid_ff;
   assign rsp_led_value = rec_ff.led;

   always_comb begin
      valid_in = valid_ff;
      slot_in  = slot_ff;
      priority if (load) begin
         valid_in = 1'b1;
         slot_in  = frx_pkg::SLOT_ECHO;
      end else if (take && rsp_last) begin
         valid_in = 1'b0;
      end else if (take) begin
         slot_in = slot_ff + 2'd1;
      end else begin
         slot_in = slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         slot_ff  <= frx_pkg::SLOT_ECHO;
      end else begin
         valid_ff <= valid_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rec_ff <= result;
      end
   end

endmodule

// File: hdl/framed_packet_receiver.sv
// Top level of the framed packet receiver: configuration registers, parser and reply stage.
// Latency: the echo byte is valid in the cycle after its input transfer.
// Throughput: one input per cycle while rsp_ready is high and each gives only its echo; a good
// frame's checksum byte holds the result register for its echo plus three reply bytes.
// Reset is synchronous and active high: parser goes idle, LED register clears,
// header byte returns to 0xAA, reply header to 0xBB and no result is pending.
module framed_packet_receiver (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_tx_byte,
   output logic                              rsp_last,
   output logic [7:0]                        rsp_led_value,
   input  logic                              csr_write_enable,
   input  logic [frx_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [7:0]                        csr_write_data
);

   logic [7:0]               header_byte_ff;
   logic [7:0]               reply_header_ff;
   logic                     load;
   logic                     free;
   frx_pkg::frx_result_type  result;

   assign req_ready = free;
   assign load      = req_valid && free;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_byte_ff  <= 8'hAA;
         reply_header_ff <= 8'hBB;
      end else if (csr_write_enable) begin
         if (csr_index == frx_pkg::REG_HEADER_BYTE) begin
            header_byte_ff <= csr_write_data;
         end
         if (csr_index == frx_pkg::REG_REPLY_HEADER) begin
            reply_header_ff <= csr_write_data;
         end
      end
   end

   frx_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .rx_byte     (req_rx_byte),
      .header_byte (header_byte_ff),
      .result      (result)
   );

   frx_reply u_reply (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .result        (result),
      .reply_header  (reply_header_ff),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_last      (rsp_last),
      .rsp_led_value (rsp_led_value),
      .free          (free)
   );

`ifndef NO_ASSERTIONS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result register not empty after reset.");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("Accepted byte produced no result.");

   a_led_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && $stable(rsp_led_value))
      else $error("LED value changed within one reply.");
`endif

endmodule

// File: tb/sv/framed_packet_receiver_test.sv
// Self-checking testbench of the framed packet receiver: predicts echo and reply bytes for random traffic.
module framed_packet_receiver_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [frx_pkg::CSR_IDX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [frx_pkg::CSR_IDX_W-1:0] REG_SPARE_3 = 2'd3;
   localparam logic [7:0] HEADER_RESET = 8'hAA;
   localparam logic [7:0] REPLY_RESET  = 8'hBB;
   localparam int RANDOM_BYTES    = 160;
   localparam int PHASE_COUNT     = 4;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
      logic [7:0] led_value;
   } tx_item_type;

   class reply_scoreboard;
      logic [7:0]                header_byte;
      logic [7:0]                reply_header;
      logic [1:0]                phase;
      logic [7:0]                expected_length;
      logic [7:0]                byte_count;
      logic [frx_pkg::SUM_W-1:0] running_sum;
      logic [7:0]                first_payload;
      logic [7:0]                led_register;
      tx_item_type               expected_tx[$];
      int                        failures;

      function new();
         header_byte = HEADER_RESET;
         reply_header = REPLY_RESET;
         phase = frx_pkg::PH_IDLE;
         expected_length = 8'h00;
         byte_count = 8'h00;
         running_sum = '0;
         first_payload = 8'h00;
         led_register = 8'h00;
         failures = 0;
      endfunction

      function logic [7:0] check_of(input int total);
         if (total > 255) return 8'(-total);
         return 8'(total);
      endfunction

      function void report(input string text);
         if (failures < REPORT_LIMIT) $display("%s", text);
         failures++;
      endfunction

      function void write_register(input logic [frx_pkg::CSR_IDX_W-1:0] index,
                                   input logic [7:0] data);
         if (index == frx_pkg::REG_HEADER_BYTE) header_byte = data;
         else if (index == frx_pkg::REG_REPLY_HEADER) reply_header = data;
      endfunction

      function void note_rx_byte(input logic [7:0] rx);
         logic       ack;
         logic [7:0] check;
         ack = 1'b0;
         check = 8'h00;
         case (phase)
            frx_pkg::PH_IDLE: begin
               running_sum = '0;
               first_payload = 8'h00;
               byte_count = 8'h00;
               if (rx == header_byte) phase = frx_pkg::PH_LENGTH;
            end
            frx_pkg::PH_LENGTH: begin
               expected_length = rx;
               phase = frx_pkg::PH_DATA;
            end
            frx_pkg::PH_DATA: begin
               if (byte_count < frx_pkg::MAX_PAYLOAD) begin
                  if (byte_count == 8'h00) first_payload = rx;
                  running_sum = running_sum + rx;
               end
               byte_count = byte_count + 8'd1;
               if (byte_count >= expected_length) phase = frx_pkg::PH_CHECK;
            end
            default: begin
               check = check_of(int'(running_sum));
               if (check == rx) begin
                  led_register = first_payload;
                  ack = 1'b1;
               end
               phase = frx_pkg::PH_IDLE;
            end
         endcase
         expected_tx.push_back('{tx_byte: rx, last: !ack, led_value: led_register});
         if (ack) begin
            expected_tx.push_back('{tx_byte: reply_header, last: 1'b0, led_value: led_register});
            expected_tx.push_back('{tx_byte: expected_length, last: 1'b0,
                                    led_value: led_register});
            expected_tx.push_back('{tx_byte: check, last: 1'b1, led_value: led_register});
         end
      endfunction

      function void check_tx_byte(input logic [7:0] tx, input logic last, input logic [7:0] led);
         tx_item_type want;
         if (expected_tx.size() == 0) begin
            report($sformatf("unexpected result: tx_byte %02h last %0d led %02h", tx, last, led));
            return;
         end
         want = expected_tx.pop_front();
         if (tx !== want.tx_byte || last !== want.last || led !== want.led_value)
            report($sformatf({"result mismatch: expected tx_byte %02h last %0d led %02h,",
                              " got tx_byte %02h last %0d led %02h"},
                             want.tx_byte, want.last, want.led_value, tx, last, led));
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [7:0]                    req_rx_byte = 8'h00;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [7:0]                    rsp_tx_byte;
   logic                          rsp_last;
   logic [7:0]                    rsp_led_value;
   logic                          csr_write_enable = 1'b0;
   logic [frx_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0]                    csr_write_data = 8'h00;

   reply_scoreboard board;
   bit              steady_flow = 1'b0;
   bit              hold_off_pending = 1'b0;
   int              rx_bytes_sent = 0;
   logic [7:0]      active_header = HEADER_RESET;
   logic [7:0]      frame_payload[$];

   framed_packet_receiver i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_last         (rsp_last),
      .rsp_led_value    (rsp_led_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      if (steady_flow) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_rx_byte(value);
      rx_bytes_sent++;
   endtask

   task automatic fill_payload(input int count);
      frame_payload.delete();
      repeat (count) frame_payload.push_back(8'($urandom));
   endtask

   task automatic send_frame(input logic [7:0] lead, input logic [7:0] length, input bit corrupt);
      int         total;
      logic [7:0] check;
      total = 0;
      for (int i = 0; i < frame_payload.size() && i < frx_pkg::MAX_PAYLOAD; i++)
         total += frame_payload[i];
      check = board.check_of(total);
      if (corrupt) check = check ^ 8'($urandom_range(1, 255));
      send_byte(lead);
      send_byte(length);
      foreach (frame_payload[i]) send_byte(frame_payload[i]);
      send_byte(check);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.expected_tx.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_register(input logic [frx_pkg::CSR_IDX_W-1:0] index,
                               input logic [7:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      board.write_register(index, data);
   endtask

   task automatic apply_settings(input logic [7:0] header, input logic [7:0] reply);
      put_register(REG_SPARE_2, 8'($urandom));
      put_register(frx_pkg::REG_HEADER_BYTE, header);
      put_register(REG_SPARE_3, 8'($urandom));
      put_register(frx_pkg::REG_REPLY_HEADER, reply);
      csr_write_enable <= 1'b0;
      active_header = header;
   endtask

   task automatic send_random_traffic(input int target);
      int r;
      int length;
      while (rx_bytes_sent < target) begin
         steady_flow = ($urandom_range(0, 4) == 0);
         r = $urandom_range(0, 99);
         if (r < 75) begin
            r = $urandom_range(0, 99);
            if (r < 8) length = 0;
            else if (r < 88) length = $urandom_range(1, 12);
            else length = $urandom_range(13, 40);
            fill_payload(length == 0 ? 1 : length);
            send_frame(active_header, 8'(length), $urandom_range(0, 4) == 0);
         end else if (r < 90) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
         end else begin
            // A frame cut short: the parser takes whatever follows as the rest of it.
            send_byte(active_header);
            send_byte(8'($urandom_range(1, 4)));
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      int first_random;
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_byte(8'h00);
      frame_payload.delete();
      frame_payload.push_back(8'hFF);
      send_frame(HEADER_RESET, 8'd0, 1'b0);
      frame_payload.delete();
      frame_payload.push_back(8'h00);
      send_frame(HEADER_RESET, 8'd1, 1'b0);
      frame_payload.delete();
      frame_payload.push_back(8'h42);
      send_frame(HEADER_RESET, 8'd1, 1'b1);
      frame_payload.delete();
      repeat (frx_pkg::MAX_PAYLOAD + 1) frame_payload.push_back(8'hFF);
      send_frame(HEADER_RESET, 8'(frx_pkg::MAX_PAYLOAD + 1), 1'b0);
      drain_results();

      first_random = rx_bytes_sent;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            1: apply_settings(8'h00, 8'hFF);
            2: apply_settings(8'hFF, 8'h00);
            3: apply_settings(8'($urandom), 8'($urandom));
            default: ;
         endcase
         if (p == 1) hold_off_pending = 1'b1;
         if (p == PHASE_COUNT - 1) begin
            fill_payload(255);
            send_frame(active_header, 8'd255, 1'b0);
         end
         send_random_traffic(first_random + RANDOM_BYTES * (p + 1) / PHASE_COUNT);
         drain_results();
      end

      repeat (8) @(posedge clock);
      if (board.failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin : result_side
      int stall;
      stall = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_valid && rsp_ready) board.check_tx_byte(rsp_tx_byte, rsp_last, rsp_led_value);
         if (stall == 0) begin
            if (hold_off_pending) begin
               hold_off_pending = 1'b0;
               stall = HOLD_OFF_CYCLES;
            end else if ($urandom_range(0, 2) == 0) begin
               stall = pick_gap();
            end
         end
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
   end

endmodule
